// ===== rtl/core/checked_signed_alu_defines.svh =====
// Shared assertion macros for the checked ALU.
`ifndef CHECKED_SIGNED_ALU_DEFINES_SVH
`define CHECKED_SIGNED_ALU_DEFINES_SVH

// Check that the consequent holds in the same cycle.
`define CSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/chk_alu_pkg.sv =====
package chk_alu_pkg;

    localparam int unsigned DataW  = 64;
    localparam int unsigned NCells = DataW;

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_REM = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    localparam logic [1:0] KIND_PASS = 2'd0;
    localparam logic [1:0] KIND_MUL  = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;
    localparam logic [1:0] KIND_REM  = 2'd3;

    // One operation in flight through the cell row.
    typedef struct packed {
        logic                 valid;
        logic [1:0]           kind;
        logic                 neg;
        logic [1:0]           status;
        logic [DataW-1:0]     x;    // divisor or multiplicand magnitude
        logic [DataW-1:0]     y;    // multiplier magnitude, MSB first
        logic [2*DataW-1:0]   w;    // {remainder, dividend/quotient} or product
    } stage_t;

endpackage

// ===== rtl/core/chk_alu_front.sv =====
module chk_alu_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [2:0]                    func,
    input  logic [chk_alu_pkg::DataW-1:0] operand_a,
    input  logic [chk_alu_pkg::DataW-1:0] operand_b,
    output chk_alu_pkg::stage_t           stage_out
);

    localparam int unsigned W = chk_alu_pkg::DataW;

    chk_alu_pkg::stage_t stage_reg;
    chk_alu_pkg::stage_t stage_next;

    logic         na;
    logic         nb;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [W-1:0] sum;
    logic [W-1:0] dif;
    logic [W-1:0] min_val;

    always_comb
    begin
        na      = operand_a[W-1];
        nb      = operand_b[W-1];
        ma      = na ? (W'(0) - operand_a) : operand_a;
        mb      = nb ? (W'(0) - operand_b) : operand_b;
        sum     = operand_a + operand_b;
        dif     = operand_a - operand_b;
        min_val = {1'b1, {(W-1){1'b0}}};

        stage_next        = '0;
        stage_next.valid  = in_valid;
        stage_next.kind   = chk_alu_pkg::KIND_PASS;
        stage_next.status = chk_alu_pkg::ST_OK;
        case (func)
            chk_alu_pkg::FUNC_ADD:
            begin
                if (na == nb && sum[W-1] != na)
                    stage_next.status = chk_alu_pkg::ST_OVERFLOW;
                else
                    stage_next.w = {{W{1'b0}}, sum};
            end
            chk_alu_pkg::FUNC_SUB:
            begin
                if (na != nb && dif[W-1] != na)
                    stage_next.status = chk_alu_pkg::ST_OVERFLOW;
                else
                    stage_next.w = {{W{1'b0}}, dif};
            end
            chk_alu_pkg::FUNC_MUL:
            begin
                stage_next.kind = chk_alu_pkg::KIND_MUL;
                stage_next.neg  = na ^ nb;
                stage_next.x    = ma;
                stage_next.y    = mb;
            end
            chk_alu_pkg::FUNC_DIV, chk_alu_pkg::FUNC_REM:
            begin
                if (operand_b == '0)
                    stage_next.status = chk_alu_pkg::ST_INVALID;
                else if (operand_a == min_val && operand_b == {W{1'b1}})
                    stage_next.status = chk_alu_pkg::ST_OVERFLOW;
                else
                begin
                    stage_next.kind = (func == chk_alu_pkg::FUNC_DIV) ?
                                      chk_alu_pkg::KIND_DIV : chk_alu_pkg::KIND_REM;
                    stage_next.neg  = (func == chk_alu_pkg::FUNC_DIV) ? (na ^ nb) : na;
                    stage_next.x    = mb;
                    stage_next.w    = {{W{1'b0}}, ma};
                end
            end
            default:
            begin
                stage_next.status = chk_alu_pkg::ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/core/chk_alu_cell.sv =====
module chk_alu_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  chk_alu_pkg::stage_t stage_in,
    output chk_alu_pkg::stage_t stage_out
);

    localparam int unsigned W = chk_alu_pkg::DataW;

    chk_alu_pkg::stage_t stage_reg;
    chk_alu_pkg::stage_t stage_next;

    logic [W:0]     trial;
    logic           ge;
    logic [2*W-1:0] addend;

    always_comb
    begin
        trial  = {stage_in.w[2*W-1:W], stage_in.w[W-1]};
        ge     = trial >= {1'b0, stage_in.x};
        addend = stage_in.y[W-1] ? {{W{1'b0}}, stage_in.x} : '0;

        stage_next = stage_in;
        case (stage_in.kind)
            chk_alu_pkg::KIND_MUL:
            begin
                // shift the partial product and add the multiplicand if the next multiplier bit is set
                stage_next.w = {stage_in.w[2*W-2:0], 1'b0} + addend;
                stage_next.y = {stage_in.y[W-2:0], 1'b0};
            end
            chk_alu_pkg::KIND_DIV, chk_alu_pkg::KIND_REM:
            begin
                // one restoring step: bring in a dividend bit, emit a quotient bit
                stage_next.w[2*W-1:W] = ge ? W'(trial - {1'b0, stage_in.x}) : trial[W-1:0];
                stage_next.w[W-1:0]   = {stage_in.w[W-2:0], ge};
            end
            default:
            begin
                stage_next = stage_in;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else if (en)
            stage_reg <= stage_next;
    end

    assign stage_out = stage_reg;

endmodule

// ===== rtl/core/chk_alu_back.sv =====
module chk_alu_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  chk_alu_pkg::stage_t           stage_in,
    output logic                          out_valid,
    output logic [chk_alu_pkg::DataW-1:0] result,
    output logic [1:0]                    status
);

    localparam int unsigned W = chk_alu_pkg::DataW;

    logic         valid_reg;
    logic [W-1:0] result_reg;
    logic [W-1:0] result_next;
    logic [1:0]   status_reg;
    logic [1:0]   status_next;
    logic [W-1:0] mag;
    logic [W-1:0] limit;

    always_comb
    begin
        limit       = stage_in.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        mag         = (stage_in.kind == chk_alu_pkg::KIND_REM) ?
                      stage_in.w[2*W-1:W] : stage_in.w[W-1:0];
        status_next = stage_in.status;
        result_next = stage_in.w[W-1:0];
        case (stage_in.kind)
            chk_alu_pkg::KIND_MUL:
            begin
                if (stage_in.w[2*W-1:W] != '0 || stage_in.w[W-1:0] > limit)
                    status_next = chk_alu_pkg::ST_OVERFLOW;
                result_next = stage_in.neg ? (W'(0) - mag) : mag;
            end
            chk_alu_pkg::KIND_DIV, chk_alu_pkg::KIND_REM:
            begin
                result_next = stage_in.neg ? (W'(0) - mag) : mag;
            end
            default:
            begin
                result_next = stage_in.w[W-1:0];
            end
        endcase
        if (status_next != chk_alu_pkg::ST_OK)
            result_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= stage_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;
    assign status    = status_reg;

endmodule

// ===== rtl/core/checked_signed_alu.sv =====
// Checked signed 64-bit ALU: add, subtract, multiply, divide, remainder.
// Input channel s_axis: tuser carries the operation code, tdata the two
// operands. Output channel m_axis: tdata carries the result, tuser the status
// (ok, overflow, invalid). Any error forces the result to zero.
// The datapath is a decode stage, a row of 64 identical cells and an output
// register. Each cell performs one shift-and-add step of the multiply or one
// restoring step of the divide, so one bit of the 64-bit operand per cell.
// Add and subtract ride through the row untouched to keep order.
// A result passes through the decode, 64 cell and output registers to m_axis.
// Throughput: one transaction per cycle; the whole row advances together.
// When the receiver stalls a waiting result, the whole row holds and
// s_axis_tready drops in the same cycle; it rises again once the result is
// taken. A new transaction is accepted in the cycle the output is consumed.
// Reset clears every valid bit; the output result and status registers are not reset.
`include "checked_signed_alu_defines.svh"

module checked_signed_alu (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // [63:0] operand_a, [127:64] operand_b
    input  logic [2:0]   s_axis_tuser,   // [2:0] func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,   // [63:0] result
    output logic [1:0]   m_axis_tuser    // [1:0] status
);

    localparam int unsigned W = chk_alu_pkg::DataW;
    localparam int unsigned N = chk_alu_pkg::NCells;

    logic                en;
    chk_alu_pkg::stage_t chain [0:N];

    // Advance the whole row unless a finished result is still waiting.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    chk_alu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .func      (s_axis_tuser),
        .operand_a (s_axis_tdata[W-1:0]),
        .operand_b (s_axis_tdata[2*W-1:W]),
        .stage_out (chain[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        chk_alu_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (chain[i]),
            .stage_out (chain[i+1])
        );
    end

    chk_alu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .stage_in  (chain[N]),
        .out_valid (m_axis_tvalid),
        .result    (m_axis_tdata),
        .status    (m_axis_tuser)
    );

    `CSA_ASSERT_SAME(a_err_zero, m_axis_tvalid && m_axis_tuser != chk_alu_pkg::ST_OK,
        m_axis_tdata == '0, "result not zero on error")
    `CSA_ASSERT_SAME(a_status_code, m_axis_tvalid,
        m_axis_tuser == chk_alu_pkg::ST_OK || m_axis_tuser == chk_alu_pkg::ST_OVERFLOW ||
        m_axis_tuser == chk_alu_pkg::ST_INVALID, "bad status code")
    `CSA_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
        $stable(chain[N]) && $stable(chain[0]), "row moved during stall")

endmodule
